@@ sv/b64d_pkg.sv @@
// b64d_pkg: shared types, codes and the character lookup for the base64 decoder.
// Used by b64d_front, b64d_queue, b64d_back and base64_stream_decoder.
// No dependencies.
package b64d_pkg;

	localparam logic [7:0] PAD_CHAR   = 8'h3D;
	localparam logic [7:0] PLUS_CHAR  = 8'h2B;
	localparam logic [7:0] SLASH_CHAR = 8'h2F;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_BAD_LENGTH = 2'd1;
	localparam logic [1:0] STATUS_BAD_CHAR   = 2'd2;

	// bit 6 set: not in the alphabet
	localparam logic [6:0] SEXTET_NONE = 7'd64;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = QUEUE_AW + 1;

	// one decoded quad (or a length error) waiting to be emitted
	typedef struct packed {
		logic [23:0] triple;
		logic [1:0]  count;
		logic        last;
		logic [1:0]  status;
	} b64d_job_t;

	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] r;
		r = SEXTET_NONE;
		if (c inside {[8'h41:8'h5A]})
			r = 7'(c - 8'h41);
		else if (c inside {[8'h61:8'h7A]})
			r = 7'(c - 8'h61 + 8'd26);
		else if (c inside {[8'h30:8'h39]})
			r = 7'(c - 8'h30 + 8'd52);
		else if (c == PLUS_CHAR)
			r = 7'd62;
		else if (c == SLASH_CHAR)
			r = 7'd63;
		return r;
	endfunction

endpackage

@@ sv/b64d_front.sv @@
// b64d_front: takes characters, maps them to sextets and gathers quads.
// Posts one job per completed quad or ragged end to the queue. Uses b64d_pkg.
module b64d_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                full,
	input  logic [7:0]          ch,
	input  logic                last,
	output logic                job_push,
	output b64d_pkg::b64d_job_t job
);
	import b64d_pkg::*;

	logic [1:0]  pos_q;
	logic [17:0] acc_q;
	logic        third_pad_q;
	logic        bad_q;

	logic        take;
	logic        is_pad;
	logic [6:0]  lut;
	logic        is_bad;
	logic [5:0]  sx;
	logic        bad_now;
	logic        pad4;
	logic        pad3;

	assign take    = push && !full;
	assign is_pad  = (ch == PAD_CHAR);
	assign lut     = sextet_of(ch);
	assign is_bad  = !is_pad && lut[6];
	assign sx      = (is_pad || lut[6]) ? 6'd0 : lut[5:0];
	assign bad_now = bad_q || is_bad;
	assign pad4    = last && is_pad;
	assign pad3    = last && third_pad_q;

	always_comb begin
		job_push = 1'b0;
		job      = '0;
		if (pos_q != 2'd3) begin
			if (last) begin
				job_push   = take;
				job.triple = '0;
				job.count  = 2'd1;
				job.last   = 1'b1;
				job.status = STATUS_BAD_LENGTH;
			end
		end else begin
			job_push   = take;
			job.triple = {acc_q, sx};
			job.count  = 2'd3 - {1'b0, pad4} - {1'b0, pad3};
			job.last   = last;
			job.status = bad_now ? STATUS_BAD_CHAR : STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 2'd0;
			acc_q       <= '0;
			third_pad_q <= 1'b0;
			bad_q       <= 1'b0;
		end else if (take) begin
			if (pos_q == 2'd3 || last) begin
				pos_q       <= 2'd0;
				acc_q       <= '0;
				third_pad_q <= 1'b0;
				bad_q       <= 1'b0;
			end else begin
				if (pos_q == 2'd2)
					third_pad_q <= is_pad;
				acc_q <= {acc_q[11:0], sx};
				pos_q <= pos_q + 2'd1;
				bad_q <= bad_now;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// a quad always restarts after its fourth character
	a_quad_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		take && pos_q == 2'd3 |=> pos_q == 2'd0 && !bad_q && !third_pad_q)
		else $error("quad position did not wrap");
`endif

endmodule

@@ sv/b64d_queue.sv @@
// b64d_queue: short job queue between the front and the back end.
// Register array, at most one write and one read per cycle (no write while full). Uses b64d_pkg.
module b64d_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  b64d_pkg::b64d_job_t din,
	input  logic                pop,
	output logic                full,
	output logic                avail,
	output b64d_pkg::b64d_job_t dout
);
	import b64d_pkg::*;

	b64d_job_t           entries_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] cnt_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (cnt_q == QUEUE_CW'(QUEUE_DEPTH));
	assign avail   = (cnt_q != '0);
	assign dout    = entries_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && avail;

	always_ff @(posedge clk) begin
		if (do_push)
			entries_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QUEUE_CW'(QUEUE_DEPTH))
		else $error("queue fill count out of range");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job posted to a full queue");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[QUEUE_AW-1:0] == QUEUE_AW'(wr_ptr_q - rd_ptr_q))
		else $error("queue pointers disagree with fill count");
`endif

endmodule

@@ sv/b64d_back.sv @@
// b64d_back: unpacks jobs into bytes, one per cycle unless the output is held, into the output register.
// Reads jobs from b64d_queue. Uses b64d_pkg.
module b64d_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                avail,
	input  b64d_pkg::b64d_job_t dout,
	output logic                q_pop,
	input  logic                pop,
	output logic                empty,
	output logic [7:0]          data_byte,
	output logic                last_byte,
	output logic [1:0]          status
);
	import b64d_pkg::*;

	b64d_job_t  job_q;
	logic       job_valid_q;
	logic [1:0] idx_q;
	logic       ovalid_q;
	logic [7:0] data_q;
	logic       last_q;
	logic [1:0] status_q;

	logic       load;
	logic       emit;
	logic       final_byte;
	logic       pull;
	logic [7:0] cur_byte;

	assign load       = !ovalid_q || pop;
	assign emit       = load && job_valid_q;
	assign final_byte = ((idx_q + 2'd1) == job_q.count);
	assign pull       = !job_valid_q || (emit && final_byte);
	assign q_pop      = pull && avail;

	always_comb begin
		case (idx_q)
			2'd0:    cur_byte = job_q.triple[23:16];
			2'd1:    cur_byte = job_q.triple[15:8];
			default: cur_byte = job_q.triple[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= 2'd0;
			ovalid_q    <= 1'b0;
		end else begin
			if (load)
				ovalid_q <= job_valid_q;
			if (pull) begin
				job_valid_q <= avail;
				idx_q       <= 2'd0;
			end else if (emit) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pull)
			job_q <= dout;
		if (emit) begin
			data_q   <= cur_byte;
			last_q   <= job_q.last && final_byte;
			status_q <= job_q.status;
		end
	end

	assign empty     = !ovalid_q;
	assign data_byte = data_q;
	assign last_byte = last_q;
	assign status    = status_q;

`ifndef NO_ASSERTIONS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q |-> idx_q < job_q.count)
		else $error("byte index beyond job length");
`endif

endmodule

@@ sv/base64_stream_decoder.sv @@
// base64_stream_decoder: streaming base64 decoder, top level.
// Instantiates b64d_front, b64d_queue and b64d_back. Uses b64d_pkg.
//
// Input channel: ch with last, a request is taken when push is high and full
// is low. last marks the final character of an encoded string.
// Result channel: data_byte, last_byte, status are valid while empty is low;
// a request is taken when pop is high and empty is low.
// Each complete quad gives three bytes (fewer on a padded final quad); a
// string ending off a quad boundary gives one result with status bad length.
// Throughput: one character per cycle sustained while results are popped; the back
// end emits one byte per cycle, so three bytes per four characters leave it slack.
// Path of a quad: its fourth character posts the job into the queue, the job
// moves on to the job register and its first byte to the byte register.
// When pop stays low the output register holds, the back end stops, the
// four-entry job queue fills and then full rises; characters already taken
// are never lost. Reset clears the quad in progress, the queue and the output.
module base64_stream_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] ch,
	input  logic       last,
	input  logic       push,
	output logic       full,
	output logic [7:0] data_byte,
	output logic       last_byte,
	output logic [1:0] status,
	output logic       empty,
	input  logic       pop
);
	import b64d_pkg::*;

	b64d_job_t job;
	b64d_job_t head;
	logic      job_push;
	logic      q_full;
	logic      q_avail;
	logic      q_pop;

	assign full = q_full;

	b64d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (q_full),
		.ch       (ch),
		.last     (last),
		.job_push (job_push),
		.job      (job)
	);

	b64d_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job),
		.pop    (q_pop),
		.full   (q_full),
		.avail  (q_avail),
		.dout   (head)
	);

	b64d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (q_avail),
		.dout      (head),
		.q_pop     (q_pop),
		.pop       (pop),
		.empty     (empty),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.status    (status)
	);

endmodule

@@ tb/sv/b64d_decode_checker.sv @@
`timescale 1ns / 100ps
// b64d_decode_checker: watches both queue-style channels of base64_stream_decoder.
// It predicts the decoded bytes of every accepted character and compares each popped result.
// Depends on b64d_pkg for the pad, plus and slash characters and the status codes.
module b64d_decode_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] ch,
	input  logic       last,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic [1:0] status,
	input  logic       empty,
	input  logic       pop,
	output int         error_count,
	output int         bytes_outstanding
);
	import b64d_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic       ends_string;
		logic [1:0] status;
	} decoded_byte_t;

	decoded_byte_t pending_bytes[$];

	// quad being gathered
	logic [1:0]  quad_pos;
	logic [17:0] sextets;
	logic        pad_in_third;
	logic        bad_char_in_quad;
	int          results_seen;

	initial begin
		error_count       = 0;
		bytes_outstanding = 0;
		results_seen      = 0;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("%0t ns  mismatch on result %0d: %s", $time, results_seen, msg);
	endtask

	// bit 6 set: character outside the alphabet
	function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
		if (c >= "A" && c <= "Z")
			return {1'b0, 6'(c - "A")};
		if (c >= "a" && c <= "z")
			return {1'b0, 6'(c - "a" + 8'd26)};
		if (c >= "0" && c <= "9")
			return {1'b0, 6'(c - "0" + 8'd52)};
		if (c == PLUS_CHAR)
			return 7'd62;
		if (c == SLASH_CHAR)
			return 7'd63;
		return 7'h40;
	endfunction

	task automatic clear_quad();
		quad_pos         = '0;
		sextets          = '0;
		pad_in_third     = 1'b0;
		bad_char_in_quad = 1'b0;
	endtask

	task automatic decode_char(input logic [7:0] c, input logic ends_string);
		logic [6:0]    lookup;
		logic [5:0]    sx;
		logic          is_pad;
		logic [23:0]   triple;
		logic [1:0]    quad_status;
		int            n_bytes;
		decoded_byte_t b;

		is_pad = (c == PAD_CHAR);
		sx     = '0;
		if (!is_pad) begin
			lookup = char_to_sextet(c);
			if (lookup[6])
				bad_char_in_quad = 1'b1;
			else
				sx = lookup[5:0];
		end

		if (quad_pos != 2'd3) begin
			if (ends_string) begin
				// string stopped mid-quad: one length error, quad dropped
				b.data        = '0;
				b.ends_string = 1'b1;
				b.status      = STATUS_BAD_LENGTH;
				pending_bytes.push_back(b);
				clear_quad();
			end else begin
				if (quad_pos == 2'd2)
					pad_in_third = is_pad;
				sextets  = {sextets[11:0], sx};
				quad_pos = quad_pos + 2'd1;
			end
		end else begin
			triple  = {sextets, sx};
			n_bytes = 3;
			// padding only trims bytes on the closing quad
			if (ends_string) begin
				if (is_pad)
					n_bytes--;
				if (pad_in_third)
					n_bytes--;
			end
			quad_status = bad_char_in_quad ? STATUS_BAD_CHAR : STATUS_OK;
			for (int k = 0; k < n_bytes; k++) begin
				b.data        = triple[23 - 8 * k -: 8];
				b.ends_string = ends_string && (k == n_bytes - 1);
				b.status      = quad_status;
				pending_bytes.push_back(b);
			end
			clear_quad();
		end
	endtask

	task automatic check_result();
		decoded_byte_t want;

		if (pending_bytes.size() == 0) begin
			report_mismatch($sformatf("unexpected byte %02h last %0b status %0d",
				data_byte, last_byte, status));
		end else begin
			want = pending_bytes.pop_front();
			if (data_byte !== want.data)
				report_mismatch($sformatf("data_byte %02h, want %02h", data_byte, want.data));
			if (last_byte !== want.ends_string)
				report_mismatch($sformatf("last_byte %0b, want %0b", last_byte,
					want.ends_string));
			if (status !== want.status)
				report_mismatch($sformatf("status %0d, want %0d", status, want.status));
		end
		results_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_quad();
			pending_bytes.delete();
		end else begin
			// a result can never stem from a request taken at the same edge
			if (pop && !empty)
				check_result();
			if (push && !full)
				decode_char(ch, last);
		end
		bytes_outstanding = pending_bytes.size();
	end

endmodule

@@ tb/sv/base64_stream_decoder_tb.sv @@
`timescale 1ns / 100ps
// base64_stream_decoder_tb: drives encoded strings into base64_stream_decoder and gives the verdict.
// Depends on b64d_pkg, the decoder RTL and b64d_decode_checker.
module base64_stream_decoder_tb;
	import b64d_pkg::*;

	localparam int CYCLE_LIMIT   = 250000;
	localparam int DRAIN_CYCLES  = 12;
	localparam int RANDOM_CHARS  = 470;

	logic       clk;
	logic       arst_n;
	logic [7:0] ch;
	logic       last;
	logic       push;
	logic       full;
	logic [7:0] data_byte;
	logic       last_byte;
	logic [1:0] status;
	logic       empty;
	logic       pop;

	int error_count;
	int bytes_outstanding;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int chars_sent    = 0;
	int cycle_count   = 0;

	base64_stream_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.ch        (ch),
		.last      (last),
		.push      (push),
		.full      (full),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.status    (status),
		.empty     (empty),
		.pop       (pop)
	);

	b64d_decode_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.ch                (ch),
		.last              (last),
		.push              (push),
		.full              (full),
		.data_byte         (data_byte),
		.last_byte         (last_byte),
		.status            (status),
		.empty             (empty),
		.pop               (pop),
		.error_count       (error_count),
		.bytes_outstanding (bytes_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [7:0] alphabet_char(input int idx);
		if (idx < 26)
			return 8'("A" + idx);
		if (idx < 52)
			return 8'("a" + idx - 26);
		if (idx < 62)
			return 8'("0" + idx - 52);
		return (idx == 62) ? PLUS_CHAR : SLASH_CHAR;
	endfunction

	// one request per call, with random idle cycles in front
	task automatic send_char(input logic [7:0] c, input logic ends_string);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		ch   <= c;
		last <= ends_string;
		@(posedge clk);
		while (full)
			@(posedge clk);
		chars_sent++;
	endtask

	task automatic send_quad(input logic [7:0] c0, input logic [7:0] c1,
		input logic [7:0] c2, input logic [7:0] c3, input logic ends_string);
		send_char(c0, 1'b0);
		send_char(c1, 1'b0);
		send_char(c2, 1'b0);
		send_char(c3, ends_string);
	endtask

	// mostly well-formed strings; some carry stray bytes or stop mid-quad
	task automatic send_random_string();
		int         n_quads;
		int         cut;
		int         pad_kind;
		logic       noisy;
		logic [7:0] q[4];

		n_quads = $urandom_range(1, 4);
		noisy   = ($urandom_range(99) < 12);
		cut     = ($urandom_range(99) < 8) ? $urandom_range(1, 3) : 4;
		for (int k = 0; k < n_quads; k++) begin
			for (int j = 0; j < 4; j++) begin
				q[j] = alphabet_char($urandom_range(63));
				if (noisy && $urandom_range(99) < 25)
					q[j] = ($urandom_range(3) == 0) ? PAD_CHAR : 8'($urandom_range(255));
			end
			if (k == n_quads - 1) begin
				pad_kind = $urandom_range(3);
				if (pad_kind == 1) begin
					q[3] = PAD_CHAR;
				end else if (pad_kind == 2) begin
					q[2] = PAD_CHAR;
					q[3] = PAD_CHAR;
				end else if (pad_kind == 3) begin
					q[2] = PAD_CHAR;
				end
				for (int j = 0; j < cut; j++)
					send_char(q[j], j == cut - 1);
			end else begin
				for (int j = 0; j < 4; j++)
					send_char(q[j], 1'b0);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push   = 1'b0;
		ch     = '0;
		last   = 1'b0;
		pop    = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 11;
		recv_idle_pct = 83;

		// directed strings
		send_quad("T", "W", "F", "u", 1'b0);
		send_quad(8'h00, SLASH_CHAR, PLUS_CHAR, "9", 1'b0);
		send_quad(PAD_CHAR, PAD_CHAR, "z", "a", 1'b0);
		send_quad(SLASH_CHAR, SLASH_CHAR, SLASH_CHAR, PAD_CHAR, 1'b1);
		send_quad("T", 8'hFF, PAD_CHAR, PAD_CHAR, 1'b1);
		send_quad("A", "B", PAD_CHAR, "C", 1'b1);
		send_char("A", 1'b1);
		send_char("A", 1'b0);
		send_char("B", 1'b0);
		send_char("C", 1'b1);

		chars_sent = 0;
		while (chars_sent < RANDOM_CHARS / 3)
			send_random_string();

		send_idle_pct = 83;
		recv_idle_pct = 11;
		while (chars_sent < 2 * RANDOM_CHARS / 3)
			send_random_string();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (chars_sent < RANDOM_CHARS)
			send_random_string();

		push <= 1'b0;
		@(negedge clk);
		while (bytes_outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ sim.f @@
sv/b64d_pkg.sv
sv/b64d_front.sv
sv/b64d_queue.sv
sv/b64d_back.sv
sv/base64_stream_decoder.sv
tb/sv/b64d_decode_checker.sv
tb/sv/base64_stream_decoder_tb.sv
